FILE: hdl/hpp_pkg.sv
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared codes, character tables and structs for the PUT request header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hpp_pkg;

   // default request size bound
   localparam int MAX_REQUEST_BYTES_DEF = 1024;

   // counter and field widths
   localparam int CountWidth  = 11;
   localparam int LengthWidth = 31;
   localparam int RoleWidth   = 3;
   localparam int ErrWidth    = 2;

   localparam logic [LengthWidth-1:0] LEN_MAX = {LengthWidth{1'b1}};

   // key length of "Content-Length:"
   localparam logic [3:0] KEY_LEN = 4'd15;

   // characters
   localparam logic [7:0] CH_CR   = 8'h0d;
   localparam logic [7:0] CH_LF   = 8'h0a;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // parser phases
   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_PATH    = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_REQTAIL = 3'd3;
   localparam logic [2:0] PH_HEADERS = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;
   localparam logic [2:0] PH_FAILED  = 3'd6;

   // length field states
   localparam logic [1:0] LF_IDLE   = 2'd0;
   localparam logic [1:0] LF_SPACES = 2'd1;
   localparam logic [1:0] LF_DIGITS = 2'd2;
   localparam logic [1:0] LF_DEAD   = 2'd3;

   // byte roles
   localparam logic [RoleWidth-1:0] ROLE_METHOD  = 3'd0;
   localparam logic [RoleWidth-1:0] ROLE_PATH    = 3'd1;
   localparam logic [RoleWidth-1:0] ROLE_VERSION = 3'd2;
   localparam logic [RoleWidth-1:0] ROLE_FRAMING = 3'd3;
   localparam logic [RoleWidth-1:0] ROLE_HEADER  = 3'd4;
   localparam logic [RoleWidth-1:0] ROLE_BODY    = 3'd5;
   localparam logic [RoleWidth-1:0] ROLE_IGNORED = 3'd6;

   // error codes
   localparam logic [ErrWidth-1:0] ERR_NONE   = 2'd0;
   localparam logic [ErrWidth-1:0] ERR_METHOD = 2'd1;
   localparam logic [ErrWidth-1:0] ERR_NO_SEP = 2'd2;

   // control from the core to the length field tracker
   typedef struct packed {
      logic step;        // run the key match / digit logic on this byte
      logic line_reset;  // LF: new header line
      logic kill;        // CR at line start: line is no length header
      logic clear;       // end of request
   } len_ctl_type;

   // status back from the length field tracker
   typedef struct packed {
      logic                   at_line_start;
      logic                   seen_next;
      logic [LengthWidth-1:0] value_next;
   } len_stat_type;

   // one result item
   typedef struct packed {
      logic [7:0]             echo_byte;
      logic [RoleWidth-1:0]   role;
      logic                   done_res;
      logic                   request_ok;
      logic [ErrWidth-1:0]    error_code;
      logic                   length_found;
      logic [LengthWidth-1:0] length_value;
      logic [CountWidth-1:0]  body_offset;
      logic [CountWidth-1:0]  path_length;
      logic [CountWidth-1:0]  version_length;
   } result_type;

   // "PUT "
   function automatic logic [7:0] method_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0:    c = 8'h50;
         2'd1:    c = 8'h55;
         2'd2:    c = 8'h54;
         default: c = 8'h20;
      endcase
      return c;
   endfunction

   // "Content-Length:"
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6f;
         4'd2:    c = 8'h6e;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6e;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2d;
         4'd8:    c = 8'h4c;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6e;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         4'd14:   c = 8'h3a;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/http_put_header_parser.sv
// An accepted item passes the input register, then the result register, before it shows on rsp_.
// Throughput: one byte per cycle unless rsp_ready stalls the result side; the per-byte
// parser step runs combinationally between the input register and the result register.
// Reset: synchronous, active high; clears both valid flags and all parser state.
// After each item flagged last the parser state returns to its reset values.
// ----------------------------------------------------------------------------
// http_put_header_parser
// Labels the bytes of a PUT request by role and reports a summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module http_put_header_parser
   import hpp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [7:0]             rsp_echo_byte,
   output      logic [RoleWidth-1:0]   rsp_role,
   output      logic                   rsp_done_res,
   output      logic                   rsp_request_ok,
   output      logic [ErrWidth-1:0]    rsp_error_code,
   output      logic                   rsp_length_found,
   output      logic [LengthWidth-1:0] rsp_length_value,
   output      logic [CountWidth-1:0]  rsp_body_offset,
   output      logic [CountWidth-1:0]  rsp_path_length,
   output      logic [CountWidth-1:0]  rsp_version_length
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       out_free;
   logic       advance;
   logic       take;

   // handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   hpp_parse_core #(
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .result    (result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_echo_byte      = out_ff.echo_byte;
   assign rsp_role           = out_ff.role;
   assign rsp_done_res       = out_ff.done_res;
   assign rsp_request_ok     = out_ff.request_ok;
   assign rsp_error_code     = out_ff.error_code;
   assign rsp_length_found   = out_ff.length_found;
   assign rsp_length_value   = out_ff.length_value;
   assign rsp_body_offset    = out_ff.body_offset;
   assign rsp_path_length    = out_ff.path_length;
   assign rsp_version_length = out_ff.version_length;

endmodule

`default_nettype wire

FILE: hdl/hpp_length_field.sv
// ----------------------------------------------------------------------------
// hpp_length_field
// Content-Length key match, space skip and saturating decimal accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_length_field
   import hpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   data_byte,
   input  wire len_ctl_type  ctl,
   output len_stat_type      stat
);

   logic [3:0]             match_ff, match_in;
   logic [1:0]             state_ff, state_in;
   logic [LengthWidth-1:0] acc_ff, acc_in;
   logic                   seen_ff, seen_in;

   logic                   is_digit;
   logic [LengthWidth+3:0] prod;
   logic [LengthWidth-1:0] acc_digit;

   // acc*10 + digit, saturating
   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign prod = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
               + {{LengthWidth{1'b0}}, data_byte[3:0]};
   assign acc_digit = (prod > {4'b0000, LEN_MAX}) ? LEN_MAX : prod[LengthWidth-1:0];

   // next state
   always_comb begin
      match_in = match_ff;
      state_in = state_ff;
      acc_in   = acc_ff;
      seen_in  = seen_ff;
      if (ctl.line_reset) begin
         match_in = 4'd0;
         state_in = LF_IDLE;
      end else if (ctl.kill) begin
         state_in = LF_DEAD;
      end else if (ctl.step) begin
         unique case (state_ff)
            LF_IDLE: begin
               if (match_ff != KEY_LEN && data_byte == key_char(match_ff)) begin
                  match_in = match_ff + 4'd1;
                  if (match_ff == KEY_LEN - 4'd1) begin
                     state_in = LF_SPACES;
                     seen_in  = 1'b1;
                     acc_in   = '0;
                  end
               end else begin
                  state_in = LF_DEAD;
               end
            end
            LF_SPACES: begin
               if (data_byte == CH_SP) begin
                  state_in = LF_SPACES;
               end else if (is_digit) begin
                  acc_in   = acc_digit;
                  state_in = LF_DIGITS;
               end else begin
                  state_in = LF_DEAD;
               end
            end
            LF_DIGITS: begin
               if (is_digit) begin
                  acc_in = acc_digit;
               end else begin
                  state_in = LF_DEAD;
               end
            end
            default: begin
               state_in = LF_DEAD;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         match_ff <= 4'd0;
         state_ff <= LF_IDLE;
         acc_ff   <= '0;
         seen_ff  <= 1'b0;
      end else begin
         match_ff <= match_in;
         state_ff <= state_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
      end
   end

   assign stat.at_line_start = (state_ff == LF_IDLE) && (match_ff == 4'd0);
   assign stat.seen_next     = seen_in;
   assign stat.value_next    = acc_in;

endmodule

`default_nettype wire

FILE: hdl/hpp_parse_core.sv
// ----------------------------------------------------------------------------
// hpp_parse_core
// Request line phases, separator search, counters and the result of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_parse_core
   import hpp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic [7:0]  data_byte,
   input  wire logic        last,
   output result_type       result
);

   localparam logic [CountWidth-1:0] COUNT_CAP =
      (MAX_REQUEST_BYTES < 2047) ? CountWidth'(MAX_REQUEST_BYTES) : 11'd2047;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v < COUNT_CAP) ? v + 11'd1 : COUNT_CAP;
   endfunction

   logic [2:0]            phase_ff, phase_in;
   logic [1:0]            midx_ff, midx_in;
   logic [1:0]            sep_ff, sep_in;
   logic [CountWidth-1:0] pos_ff, pos_in;
   logic [CountWidth-1:0] bstart_ff, bstart_in;
   logic                  bseen_ff, bseen_in;
   logic [CountWidth-1:0] path_ff, path_in;
   logic [CountWidth-1:0] ver_ff, ver_in;
   logic                  lscr_ff, lscr_in;
   logic                  mbad_ff, mbad_in;
   logic                  term_ff, term_in;

   logic [RoleWidth-1:0]  role;
   logic [ErrWidth-1:0]   err;
   len_ctl_type           lctl;
   len_stat_type          lstat;

   hpp_length_field u_len (
      .clock     (clock),
      .reset     (reset),
      .data_byte (data_byte),
      .ctl       (lctl),
      .stat      (lstat)
   );

   // per byte parse step
   always_comb begin
      phase_in  = phase_ff;
      midx_in   = midx_ff;
      sep_in    = sep_ff;
      bstart_in = bstart_ff;
      bseen_in  = bseen_ff;
      path_in   = path_ff;
      ver_in    = ver_ff;
      lscr_in   = lscr_ff;
      mbad_in   = mbad_ff;
      term_in   = term_ff;
      role      = ROLE_IGNORED;
      lctl      = '0;
      lctl.clear = en && last;

      if (en && !term_ff && phase_ff != PH_FAILED) begin
         if (data_byte == CH_NUL) begin
            term_in = 1'b1;
            if (phase_ff == PH_METHOD) begin
               mbad_in  = 1'b1;
               phase_in = PH_FAILED;
            end
         end else begin
            // first CR LF CR LF marks the body start
            if (data_byte == CH_CR) begin
               sep_in = (sep_ff == 2'd2) ? 2'd3 : 2'd1;
            end else if (data_byte == CH_LF && sep_ff == 2'd1) begin
               sep_in = 2'd2;
            end else if (data_byte == CH_LF && sep_ff == 2'd3) begin
               sep_in = 2'd0;
               if (!bseen_ff) begin
                  bseen_in  = 1'b1;
                  bstart_in = sat_inc(pos_ff);
               end
            end else begin
               sep_in = 2'd0;
            end

            unique case (phase_ff)
               PH_METHOD: begin
                  role = ROLE_METHOD;
                  if (data_byte == method_char(midx_ff)) begin
                     if (midx_ff == 2'd3) begin
                        midx_in  = 2'd0;
                        phase_in = PH_PATH;
                     end else begin
                        midx_in = midx_ff + 2'd1;
                     end
                  end else begin
                     mbad_in  = 1'b1;
                     phase_in = PH_FAILED;
                  end
               end
               PH_PATH: begin
                  if (data_byte == CH_SP) begin
                     role     = ROLE_FRAMING;
                     phase_in = PH_VERSION;
                  end else begin
                     role    = ROLE_PATH;
                     path_in = sat_inc(path_ff);
                  end
               end
               PH_VERSION: begin
                  if (data_byte == CH_LF) begin
                     role     = ROLE_FRAMING;
                     phase_in = PH_HEADERS;
                  end else if (data_byte == CH_CR) begin
                     role     = ROLE_FRAMING;
                     phase_in = PH_REQTAIL;
                  end else begin
                     role   = ROLE_VERSION;
                     ver_in = sat_inc(ver_ff);
                  end
               end
               PH_REQTAIL: begin
                  role = ROLE_FRAMING;
                  if (data_byte == CH_LF) begin
                     phase_in = PH_HEADERS;
                  end
               end
               PH_HEADERS: begin
                  if (lscr_ff) begin
                     // byte after a CR at line start
                     lscr_in = 1'b0;
                     if (data_byte == CH_LF) begin
                        role     = ROLE_FRAMING;
                        phase_in = PH_BODY;
                     end else begin
                        role = (data_byte == CH_CR) ? ROLE_FRAMING : ROLE_HEADER;
                     end
                  end else if (lstat.at_line_start && data_byte == CH_CR) begin
                     lscr_in   = 1'b1;
                     lctl.kill = 1'b1;
                     role      = ROLE_FRAMING;
                  end else if (data_byte == CH_LF) begin
                     lctl.line_reset = 1'b1;
                     role            = ROLE_FRAMING;
                  end else begin
                     lctl.step = 1'b1;
                     role = (data_byte == CH_CR) ? ROLE_FRAMING : ROLE_HEADER;
                  end
               end
               default: begin
                  role = ROLE_BODY;
               end
            endcase
         end
      end
   end

   assign pos_in = sat_inc(pos_ff);

   // state registers, back to reset after the last byte
   always_ff @(posedge clock) begin
      if (reset || (en && last)) begin
         phase_ff  <= PH_METHOD;
         midx_ff   <= 2'd0;
         sep_ff    <= 2'd0;
         pos_ff    <= '0;
         bstart_ff <= '0;
         bseen_ff  <= 1'b0;
         path_ff   <= '0;
         ver_ff    <= '0;
         lscr_ff   <= 1'b0;
         mbad_ff   <= 1'b0;
         term_ff   <= 1'b0;
      end else if (en) begin
         phase_ff  <= phase_in;
         midx_ff   <= midx_in;
         sep_ff    <= sep_in;
         pos_ff    <= pos_in;
         bstart_ff <= bstart_in;
         bseen_ff  <= bseen_in;
         path_ff   <= path_in;
         ver_ff    <= ver_in;
         lscr_ff   <= lscr_in;
         mbad_ff   <= mbad_in;
         term_ff   <= term_in;
      end
   end

   // result of this byte, summary only on the last one
   assign err = mbad_in ? ERR_METHOD : (bseen_in ? ERR_NONE : ERR_NO_SEP);

   always_comb begin
      result                = '0;
      result.echo_byte      = data_byte;
      result.role           = role;
      result.done_res       = last;
      if (last) begin
         result.request_ok = (err == ERR_NONE);
         result.error_code = err;
         if (!mbad_in) begin
            result.length_found   = lstat.seen_next;
            result.length_value   = lstat.seen_next ? lstat.value_next : '0;
            result.body_offset    = bseen_in ? bstart_in : '0;
            result.path_length    = path_in;
            result.version_length = ver_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/hpp_checker.sv
// ----------------------------------------------------------------------------
// hpp_checker
// Port-level checks on the result channel of the PUT request header parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_checker
   import hpp_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [7:0]             rsp_echo_byte,
   input wire logic [RoleWidth-1:0]   rsp_role,
   input wire logic                   rsp_done_res,
   input wire logic                   rsp_request_ok,
   input wire logic [ErrWidth-1:0]    rsp_error_code,
   input wire logic                   rsp_length_found,
   input wire logic [LengthWidth-1:0] rsp_length_value,
   input wire logic [CountWidth-1:0]  rsp_body_offset,
   input wire logic [CountWidth-1:0]  rsp_path_length,
   input wire logic [CountWidth-1:0]  rsp_version_length
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte) && $stable(rsp_role))
      else $error("result item changed while stalled");

   // summary fields are zero except on the last item
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_request_ok && rsp_error_code == ERR_NONE
         && !rsp_length_found && rsp_body_offset == '0 && rsp_path_length == '0)
      else $error("summary field set on an item that is not last");

   // ok flag agrees with the error code
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_request_ok == (rsp_error_code == ERR_NONE)
         && rsp_error_code <= ERR_NO_SEP)
      else $error("request_ok disagrees with error_code");

   // a bad method leaves every parsed field empty
   a_bad_method: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_METHOD |-> !rsp_length_found
         && rsp_length_value == '0 && rsp_path_length == '0
         && rsp_version_length == '0 && rsp_body_offset == '0)
      else $error("parsed fields set after a bad method");

   // no length without a length header
   a_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_length_found |-> rsp_length_value == '0)
      else $error("content length set without a length header");

endmodule

bind http_put_header_parser hpp_checker u_hpp_checker (.*);

`default_nettype wire

FILE: verif/tb_http_put_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_put_header_parser
// Streams PUT requests byte by byte through the parser and checks the role of
// every byte and the summary on the closing byte against a local parser model.
// A short table of hand-written bytes comes first; then come generated
// requests with random content, noise and broken framing. Both handshakes idle
// at random.
// ----------------------------------------------------------------------------

module tb_http_put_header_parser;
   import hpp_pkg::*;

   localparam int COUNT_CAP      = (MAX_REQUEST_BYTES_DEF < 2047) ? MAX_REQUEST_BYTES_DEF : 2047;
   localparam int RANDOM_ITEMS   = 730;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int DIRECTED_ROWS  = 20;
   localparam int LONG_PATH      = 1;
   localparam int LONG_VERSION   = 2;

   localparam logic [31:0]  PUT_WORD   = "PUT ";
   localparam logic [119:0] LENGTH_KEY = "Content-Length:";

   // one row of the hand-written byte table; the pinned fields apply when pinned is set
   typedef struct packed {
      logic [7:0]           data;
      logic                 last;
      logic                 pinned;
      logic [RoleWidth-1:0] role;
      logic                 done;
      logic                 ok;
      logic [ErrWidth-1:0]  err;
   } step_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_echo_byte;
   logic [RoleWidth-1:0]   rsp_role;
   logic                   rsp_done_res;
   logic                   rsp_request_ok;
   logic [ErrWidth-1:0]    rsp_error_code;
   logic                   rsp_length_found;
   logic [LengthWidth-1:0] rsp_length_value;
   logic [CountWidth-1:0]  rsp_body_offset;
   logic [CountWidth-1:0]  rsp_path_length;
   logic [CountWidth-1:0]  rsp_version_length;

   result_type   expected_labels [$];
   logic [7:0]   request_bytes [$];
   step_row_type directed_steps [DIRECTED_ROWS];
   int           failures = 0;
   int           sent_items = 0;
   int           idle_cycles = 0;

   // parser model state
   logic [2:0]             pr_phase;
   logic [3:0]             pr_match;
   logic [1:0]             pr_field;
   logic [LengthWidth-1:0] pr_length;
   logic                   pr_length_seen;
   logic [2:0]             pr_sep;
   int                     pr_pos;
   int                     pr_body_start;
   logic                   pr_body_seen;
   int                     pr_path;
   int                     pr_version;
   logic                   pr_line_cr;
   logic                   pr_bad_method;
   logic                   pr_stopped;

   http_put_header_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_role           (rsp_role),
      .rsp_done_res       (rsp_done_res),
      .rsp_request_ok     (rsp_request_ok),
      .rsp_error_code     (rsp_error_code),
      .rsp_length_found   (rsp_length_found),
      .rsp_length_value   (rsp_length_value),
      .rsp_body_offset    (rsp_body_offset),
      .rsp_path_length    (rsp_path_length),
      .rsp_version_length (rsp_version_length)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------
   function automatic void clear_parser();
      pr_phase       = PH_METHOD;
      pr_match       = '0;
      pr_field       = LF_IDLE;
      pr_length      = '0;
      pr_length_seen = 1'b0;
      pr_sep         = '0;
      pr_pos         = 0;
      pr_body_start  = 0;
      pr_body_seen   = 1'b0;
      pr_path        = 0;
      pr_version     = 0;
      pr_line_cr     = 1'b0;
      pr_bad_method  = 1'b0;
      pr_stopped     = 1'b0;
   endfunction

   function automatic int bump_count(int v);
      return (v < COUNT_CAP) ? v + 1 : COUNT_CAP;
   endfunction

   // decimal accumulate, saturating at the top of the length range
   function automatic void add_digit(logic [7:0] b);
      longint unsigned d;
      longint unsigned acc;
      d   = b - CH_ZERO;
      acc = pr_length;
      if (acc > (longint'(LEN_MAX) - d) / 10)
         pr_length = LEN_MAX;
      else
         pr_length = LengthWidth'(acc * 10 + d);
   endfunction

   // key match, space skip and digit run of a length header
   function automatic void track_length_field(logic [7:0] b);
      logic is_digit;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      case (pr_field)
         LF_IDLE: begin
            if (pr_match < KEY_LEN && b == LENGTH_KEY[8*(14-int'(pr_match)) +: 8]) begin
               pr_match = pr_match + 4'd1;
               if (pr_match == KEY_LEN) begin
                  pr_field       = LF_SPACES;
                  pr_length_seen = 1'b1;
                  pr_length      = '0;
               end
            end else begin
               pr_field = LF_DEAD;
            end
         end
         LF_SPACES: begin
            if (b != CH_SP) begin
               if (is_digit) begin
                  add_digit(b);
                  pr_field = LF_DIGITS;
               end else begin
                  pr_field = LF_DEAD;
               end
            end
         end
         LF_DIGITS: begin
            if (is_digit)
               add_digit(b);
            else
               pr_field = LF_DEAD;
         end
         default: ;
      endcase
   endfunction

   // first CR LF CR LF in the stream, up to a zero byte or a bad method, marks the body start
   function automatic void track_separator(logic [7:0] b);
      if (b == CH_CR) begin
         pr_sep = (pr_sep == 3'd2) ? 3'd3 : 3'd1;
      end else if (b == CH_LF && pr_sep == 3'd1) begin
         pr_sep = 3'd2;
      end else if (b == CH_LF && pr_sep == 3'd3) begin
         pr_sep = 3'd0;
         if (!pr_body_seen) begin
            pr_body_seen  = 1'b1;
            pr_body_start = bump_count(pr_pos);
         end
      end else begin
         pr_sep = 3'd0;
      end
   endfunction

   function automatic logic [RoleWidth-1:0] label_header_byte(logic [7:0] b);
      if (pr_line_cr) begin
         pr_line_cr = 1'b0;
         if (b == CH_LF) begin
            pr_phase = PH_BODY;
            return ROLE_FRAMING;
         end
      end else if (pr_field == LF_IDLE && pr_match == 0 && b == CH_CR) begin
         pr_line_cr = 1'b1;
         pr_field   = LF_DEAD;
         return ROLE_FRAMING;
      end
      if (b == CH_LF) begin
         pr_match = '0;
         pr_field = LF_IDLE;
         return ROLE_FRAMING;
      end
      track_length_field(b);
      return (b == CH_CR) ? ROLE_FRAMING : ROLE_HEADER;
   endfunction

   // label one byte and build the expected result item
   function automatic result_type label_byte(logic [7:0] b, logic last);
      result_type          r;
      logic [RoleWidth-1:0] role;
      logic [ErrWidth-1:0]  err;
      role = ROLE_IGNORED;
      if (!pr_stopped && pr_phase != PH_FAILED) begin
         if (b == CH_NUL) begin
            pr_stopped = 1'b1;
            if (pr_phase == PH_METHOD) begin
               pr_bad_method = 1'b1;
               pr_phase      = PH_FAILED;
            end
         end else begin
            track_separator(b);
            case (pr_phase)
               PH_METHOD: begin
                  role = ROLE_METHOD;
                  if (pr_match < 4 && b == PUT_WORD[8*(3-int'(pr_match)) +: 8]) begin
                     pr_match = pr_match + 4'd1;
                     if (pr_match == 4) begin
                        pr_match = '0;
                        pr_phase = PH_PATH;
                     end
                  end else begin
                     pr_bad_method = 1'b1;
                     pr_phase      = PH_FAILED;
                  end
               end
               PH_PATH: begin
                  if (b == CH_SP) begin
                     role     = ROLE_FRAMING;
                     pr_phase = PH_VERSION;
                  end else begin
                     role    = ROLE_PATH;
                     pr_path = bump_count(pr_path);
                  end
               end
               PH_VERSION: begin
                  if (b == CH_LF) begin
                     role     = ROLE_FRAMING;
                     pr_phase = PH_HEADERS;
                  end else if (b == CH_CR) begin
                     role     = ROLE_FRAMING;
                     pr_phase = PH_REQTAIL;
                  end else begin
                     role       = ROLE_VERSION;
                     pr_version = bump_count(pr_version);
                  end
               end
               PH_REQTAIL: begin
                  role = ROLE_FRAMING;
                  if (b == CH_LF)
                     pr_phase = PH_HEADERS;
               end
               PH_HEADERS: role = label_header_byte(b);
               default:    role = ROLE_BODY;
            endcase
         end
      end
      pr_pos = bump_count(pr_pos);

      r           = '0;
      r.echo_byte = b;
      r.role      = role;
      r.done_res  = last;
      if (last) begin
         err          = pr_bad_method ? ERR_METHOD : (pr_body_seen ? ERR_NONE : ERR_NO_SEP);
         r.request_ok = (err == ERR_NONE);
         r.error_code = err;
         if (!pr_bad_method) begin
            r.length_found   = pr_length_seen;
            r.length_value   = pr_length_seen ? pr_length : '0;
            r.body_offset    = pr_body_seen ? CountWidth'(pr_body_start) : '0;
            r.path_length    = CountWidth'(pr_path);
            r.version_length = CountWidth'(pr_version);
         end
         clear_parser();
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // request generation
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [7:0] text_byte();
      return 8'($urandom_range(8'h21, 8'h7e));
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++)
         request_bytes.push_back(s[i]);
   endfunction

   function automatic void push_line_end();
      if ($urandom_range(0, 4) == 0) begin
         request_bytes.push_back(CH_LF);
      end else begin
         request_bytes.push_back(CH_CR);
         request_bytes.push_back(CH_LF);
      end
   endfunction

   // mostly well-formed requests with random content, some broken or pure noise
   function automatic void build_request(int long_part);
      int n;
      int h;
      int k;
      request_bytes.delete();

      // noise
      if (long_part == 0 && $urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8)) request_bytes.push_back(any_byte());
         return;
      end

      // request line
      push_text("PUT ");
      n = (long_part == LONG_PATH) ? COUNT_CAP + 6 : $urandom_range(0, 6);
      repeat (n)
         request_bytes.push_back((long_part == 0 && $urandom_range(0, 15) == 0) ?
                                 any_byte() : text_byte());
      request_bytes.push_back(CH_SP);
      if (long_part == LONG_VERSION)
         repeat (COUNT_CAP + 6) request_bytes.push_back(text_byte());
      else if ($urandom_range(0, 1) == 0)
         push_text("HTTP/1.1");
      else
         repeat ($urandom_range(0, 6)) request_bytes.push_back(text_byte());
      case ($urandom_range(0, 9))
         7: request_bytes.push_back(CH_LF);
         8, 9: begin
            request_bytes.push_back(CH_CR);
            repeat ($urandom_range(1, 3)) request_bytes.push_back(text_byte());
            request_bytes.push_back(CH_LF);
         end
         default: begin
            request_bytes.push_back(CH_CR);
            request_bytes.push_back(CH_LF);
         end
      endcase

      // header lines
      for (h = $urandom_range(0, 3); h > 0; h--) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               push_text("Content-Length:");
               repeat ($urandom_range(0, 3)) request_bytes.push_back(CH_SP);
               case ($urandom_range(0, 7))
                  0: push_text("2147483647");
                  1: push_text("2147483648");
                  2: push_text("99999999999999");
                  default:
                     repeat ($urandom_range(1, 9))
                        request_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
               endcase
               // trailing junk, possibly a CR that stops the digits
               if ($urandom_range(0, 3) == 0) begin
                  request_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_CR : text_byte());
                  request_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
               end
            end
            2: begin
               // near miss on the key
               n = $urandom_range(1, 14);
               for (k = 0; k < n; k++)
                  request_bytes.push_back(LENGTH_KEY[8*(14-k) +: 8]);
               request_bytes.push_back(text_byte());
            end
            3: repeat ($urandom_range(0, 8))
                  request_bytes.push_back(($urandom_range(0, 9) == 0) ? CH_CR : text_byte());
            default: begin
               // CR at line start not followed by LF
               request_bytes.push_back(CH_CR);
               repeat ($urandom_range(1, 5)) request_bytes.push_back(text_byte());
            end
         endcase
         push_line_end();
      end

      // end of headers, then body
      push_line_end();
      repeat ($urandom_range(0, 5)) request_bytes.push_back(any_byte());

      if (long_part != 0)
         return;
      if ($urandom_range(0, 13) == 0)
         request_bytes[$urandom_range(0, 3)] = any_byte();
      if ($urandom_range(0, 9) == 0)
         request_bytes[$urandom_range(0, request_bytes.size() - 1)] = any_byte();
      if ($urandom_range(0, 11) == 0)
         request_bytes[$urandom_range(0, request_bytes.size() - 1)] = CH_NUL;
      if ($urandom_range(0, 11) == 0) begin
         n = $urandom_range(1, request_bytes.size());
         while (request_bytes.size() > n)
            void'(request_bytes.pop_back());
      end
   endfunction

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------
   // present one byte and wait until it is taken; valid stays up when no gap follows
   task automatic offer_byte(input logic [7:0] b, input logic last, input logic calm);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last      <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_request();
      logic       calm;
      result_type want;
      int         i;
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < request_bytes.size(); i++) begin
         offer_byte(request_bytes[i], i == request_bytes.size() - 1, calm);
         want = label_byte(request_bytes[i], i == request_bytes.size() - 1);
         sent_items++;
         expected_labels.push_back(want);
      end
   endtask

   // result side: runs of ready with random stalls between them
   initial begin
      int run;
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_labels.size() == 0) begin
            $error("result item with no byte outstanding");
            failures++;
         end else begin
            want = expected_labels.pop_front();
            check_field("echo_byte", want.echo_byte, rsp_echo_byte);
            check_field("role", want.role, rsp_role);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("request_ok", want.request_ok, rsp_request_ok);
            check_field("error_code", want.error_code, rsp_error_code);
            check_field("length_found", want.length_found, rsp_length_found);
            check_field("length_value", want.length_value, rsp_length_value);
            check_field("body_offset", want.body_offset, rsp_body_offset);
            check_field("path_length", want.path_length, rsp_path_length);
            check_field("version_length", want.version_length, rsp_version_length);
         end
      end
   end

   // hang detection: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      result_type want;
      int         i;

      clear_parser();
      // bad method byte, zero byte, a full short request, a request with no separator
      directed_steps = '{
         '{8'hff, 1'b1, 1'b1, ROLE_METHOD,  1'b1, 1'b0, ERR_METHOD},
         '{8'h00, 1'b1, 1'b1, ROLE_IGNORED, 1'b1, 1'b0, ERR_METHOD},
         '{"P",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"U",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"T",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{" ",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"/",   1'b0, 1'b1, ROLE_PATH,    1'b0, 1'b0, ERR_NONE},
         '{CH_CR, 1'b0, 1'b0, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{" ",   1'b0, 1'b1, ROLE_FRAMING, 1'b0, 1'b0, ERR_NONE},
         '{"x",   1'b0, 1'b1, ROLE_VERSION, 1'b0, 1'b0, ERR_NONE},
         '{CH_CR, 1'b0, 1'b0, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{CH_LF, 1'b0, 1'b0, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{CH_CR, 1'b0, 1'b0, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{CH_LF, 1'b0, 1'b0, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"Z",   1'b1, 1'b1, ROLE_BODY,    1'b1, 1'b1, ERR_NONE},
         '{"P",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"U",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"T",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{" ",   1'b0, 1'b1, ROLE_METHOD,  1'b0, 1'b0, ERR_NONE},
         '{"a",   1'b1, 1'b1, ROLE_PATH,    1'b1, 1'b0, ERR_NO_SEP}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // hand-written bytes
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         offer_byte(directed_steps[i].data, directed_steps[i].last, 1'b0);
         want = label_byte(directed_steps[i].data, directed_steps[i].last);
         if (directed_steps[i].pinned) begin
            want.role       = directed_steps[i].role;
            want.done_res   = directed_steps[i].done;
            want.request_ok = directed_steps[i].ok;
            want.error_code = directed_steps[i].err;
         end
         expected_labels.push_back(want);
      end

      // generated requests
      while (sent_items < RANDOM_ITEMS) begin
         build_request(0);
         send_request();
      end
      req_valid <= 1'b0;

      // drain
      while (expected_labels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
